// File: rtl/core/bsf_pkg.sv
`default_nettype none

package bsf_pkg;

	// Defaults for the top-level parameters
	localparam int STORE_DEPTH_DEF = 4096;
	localparam int MAX_POP_DEF     = 64;

	// Capacity register
	localparam int CAP_W = 13;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_CLOSE  = 2'd2,
		OP_STATUS = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  push_byte;
		logic [6:0]  pop_length;
	} item_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic        last;
		logic        push_accepted;
		logic [12:0] fill_level;
		logic [12:0] free_space;
		logic [63:0] total_pushed;
		logic [63:0] total_popped;
		logic        closed;
		logic        finished;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;     // input beat taken, update state by opcode
		logic load_stat;  // load a status-only result
		logic issue;      // read next byte from the store
		logic move;       // read data into the output register
	} bsf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pop_nonzero; // offered item is a pop that removes bytes
		logic out_free;    // output register can take a result this cycle
		logic rd_valid;    // read register holds a byte
		logic remain_zero; // no more reads to issue
	} bsf_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bsf_ctrl.sv
`default_nettype none

module bsf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire bsf_pkg::bsf_stat_t stat,
	output bsf_pkg::bsf_cmd_t      cmd
);
	import bsf_pkg::*;

	ctl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		item_ready     = 1'b0;
		cmd.accept     = 1'b0;
		cmd.load_stat  = 1'b0;
		cmd.issue      = 1'b0;
		cmd.move       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready    = stat.out_free;
				cmd.accept    = item_valid && stat.out_free;
				cmd.load_stat = cmd.accept && !stat.pop_nonzero;
				if (cmd.accept && stat.pop_nonzero) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				// one byte per cycle through the read register while the output register is free
				cmd.move  = stat.rd_valid && stat.out_free;
				cmd.issue = !stat.remain_zero && (!stat.rd_valid || cmd.move);
				if (stat.remain_zero && (!stat.rd_valid || cmd.move)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/bsf_datapath.sv
`default_nettype none

module bsf_datapath #(
	parameter int STORE_DEPTH = bsf_pkg::STORE_DEPTH_DEF,
	parameter int MAX_POP     = bsf_pkg::MAX_POP_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bsf_pkg::item_t           item,
	input  wire logic                     cfg_valid,
	input  wire logic [bsf_pkg::CAP_W-1:0] cfg_data,
	input  wire logic                     result_ready,
	output logic                          result_valid,
	output bsf_pkg::result_t              result,
	input  wire bsf_pkg::bsf_cmd_t        cmd,
	output bsf_pkg::bsf_stat_t            stat
);
	import bsf_pkg::*;

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int POP_W = $clog2(MAX_POP + 1);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STORE_DEPTH - 1);
	localparam logic [6:0]       MAX_POP_L = 7'(MAX_POP);

	logic [7:0]       mem [STORE_DEPTH];

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] wr_idx_q, rd_idx_q;
	logic [63:0]      pushed_q, popped_q;
	logic             closed_q;
	logic [POP_W-1:0] remain_q;
	logic             rd_valid_q, rd_last_q;
	logic [7:0]       rd_byte_q;
	logic             out_valid_q, out_bv_q, out_last_q, out_acc_q;
	logic [7:0]       out_byte_q;

	logic [CNT_W-1:0] eff_cap;
	logic [31:0]      cap32, eff32, fill32, free32, n32;
	logic             push_acc;
	logic [6:0]       plen_sat;
	logic [POP_W-1:0] pop_n;
	logic             is_push, is_pop, do_write;

	// Effective capacity, push admission and pop size
	always_comb begin
		cap32    = 32'(cap_q);
		eff32    = (cap32 < 32'(STORE_DEPTH)) ? cap32 : 32'(STORE_DEPTH);
		eff_cap  = CNT_W'(eff32);
		fill32   = 32'(fill_q);
		free32   = (eff32 > fill32) ? (eff32 - fill32) : 32'd0;
		push_acc = fill_q < eff_cap;
		plen_sat = (item.pop_length > MAX_POP_L) ? MAX_POP_L : item.pop_length;
		n32      = (32'(plen_sat) < fill32) ? 32'(plen_sat) : fill32;
		pop_n    = POP_W'(n32);
		is_push  = item.opcode == OP_PUSH;
		is_pop   = item.opcode == OP_POP;
		do_write = cmd.accept && is_push && push_acc;
	end

	assign stat.pop_nonzero = is_pop && (pop_n != '0);
	assign stat.out_free    = !out_valid_q || result_ready;
	assign stat.rd_valid    = rd_valid_q;
	assign stat.remain_zero = remain_q == '0;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			pushed_q <= '0;
			popped_q <= '0;
			closed_q <= 1'b0;
			remain_q <= '0;
		end else begin
			if (cmd.accept) begin
				case (item.opcode)
					OP_PUSH: begin
						if (push_acc) begin
							wr_idx_q <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + IDX_W'(1);
							fill_q   <= fill_q + CNT_W'(1);
							pushed_q <= pushed_q + 64'd1;
						end
					end
					OP_POP: begin
						fill_q   <= fill_q - CNT_W'(pop_n);
						popped_q <= popped_q + 64'(pop_n);
						remain_q <= pop_n;
					end
					OP_CLOSE: begin
						closed_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.issue) begin
				rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + IDX_W'(1);
				remain_q <= remain_q - POP_W'(1);
			end
		end
	end

	// Byte store write port
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_idx_q] <= item.push_byte;
		end
	end

	// Byte store read port, registered
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_byte_q <= mem[rd_idx_q];
			rd_last_q <= remain_q == POP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else if (cmd.issue) begin
			rd_valid_q <= 1'b1;
		end else if (cmd.move) begin
			rd_valid_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_stat || cmd.move) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_stat) begin
			out_bv_q   <= 1'b0;
			out_byte_q <= 8'd0;
			out_last_q <= 1'b1;
			out_acc_q  <= is_push && push_acc;
		end else if (cmd.move) begin
			out_bv_q   <= 1'b1;
			out_byte_q <= rd_byte_q;
			out_last_q <= rd_last_q;
			out_acc_q  <= 1'b0;
		end
	end

	// Status fields follow the live state: it changes when an input beat is taken or the capacity is written
	assign result_valid          = out_valid_q;
	assign result.byte_valid     = out_bv_q;
	assign result.out_byte       = out_byte_q;
	assign result.last           = out_last_q;
	assign result.push_accepted  = out_acc_q;
	assign result.fill_level     = fill32[12:0];
	assign result.free_space     = free32[12:0];
	assign result.total_pushed   = pushed_q;
	assign result.total_popped   = popped_q;
	assign result.closed         = closed_q;
	assign result.finished       = closed_q && (fill_q == '0);

endmodule

`default_nettype wire

// File: rtl/core/bounded_byte_stream_fifo.sv
`default_nettype none

// Byte FIFO with a software capacity and a sticky close flag. Each input beat is
// a push, a pop of up to MAX_POP bytes, a close or a status query; every result
// beat carries the buffered and free counts, the 64-bit pushed and popped totals
// and the closed and finished flags as they stand after the whole input beat.
// Push, close and status beats can be accepted one per cycle while results are
// taken. A pop that removes n bytes gives n result beats, one per cycle while
// results are taken, through the store's single registered read port; the
// first byte passes through the read register and then the output register,
// and no input beat is taken until the last byte has reached the output
// register. A pop that removes nothing gives one status beat.
// The byte store needs no clearing after reset.
// The capacity port is always ready and must be written only while idle.
module bounded_byte_stream_fifo #(
	parameter int STORE_DEPTH = bsf_pkg::STORE_DEPTH_DEF,
	parameter int MAX_POP     = bsf_pkg::MAX_POP_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire bsf_pkg::item_t            item,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output bsf_pkg::result_t               result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [bsf_pkg::CAP_W-1:0] cfg_data
);
	import bsf_pkg::*;

	bsf_cmd_t  cmd;
	bsf_stat_t stat;

	assign cfg_ready = 1'b1;

	bsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	bsf_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_POP     (MAX_POP)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

`default_nettype wire
